// ----- hdl/bsbz_pkg.sv -----
// Package for the B-spline to Bezier converter: coordinate widths, divide-by-six
// reciprocal constants, Bezier point select codes and pipeline tag type.
// No dependencies.
package bsbz_pkg;

    localparam int CW         = 32;
    localparam int COMPONENTS = 4;
    localparam int LANES      = 4;

    localparam int SUM_W       = CW + 4;
    localparam int U_W         = CW + 2;
    localparam int RECIP_SHIFT = U_W + 2;
    localparam int M_W         = RECIP_SHIFT - 1;
    localparam int M_LO_W      = M_W / 2;
    localparam int M_HI_W      = M_W - M_LO_W;
    localparam int P_W         = U_W + M_W;
    localparam int Q_W         = P_W - RECIP_SHIFT;

    localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3;
    localparam logic [M_LO_W-1:0] RECIP_LO = M_LO_W'(RECIP_FULL);
    localparam logic [M_HI_W-1:0] RECIP_HI = M_HI_W'(RECIP_FULL >> M_LO_W);

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [1:0] {
        BEZ_B0 = 2'd0,
        BEZ_B1 = 2'd1,
        BEZ_B2 = 2'd2,
        BEZ_B3 = 2'd3
    } bez_sel_t;

    typedef struct packed {
        logic run_end;
        logic curve_end;
    } tag_t;

endpackage

// ----- hdl/bspline_to_bezier_converter.sv -----
// Uniform cubic B-spline to Bezier converter: point window, segment sequencer and
// five-stage divide-by-six pipeline. Depends on bsbz_pkg.
//
//  channel   direction  handshake               payload
//  input     in         in_valid / in_ready     px py pz pw final_point
//  output    out        out_valid / out_ready   bx by bz bw run_end curve_end
//  config    in         joint_mode_wr_en        joint_mode_wr_data
//
// An input word that completes a window yields one result per Bezier point (four in
// separate mode, three in shared mode, four on the final point); the segment
// sequencer issues one Bezier point a cycle unless the output stalls. Issued points
// pass through registers s1 to s4 and out. Reset clears the count, mode and all valid
// flags; the point window is not cleared. An output stall holds the whole pipeline.
module bspline_to_bezier_converter
    import bsbz_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         joint_mode_wr_en,
    input  logic         joint_mode_wr_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [CW-1:0] px,
    input  logic [CW-1:0] py,
    input  logic [CW-1:0] pz,
    input  logic [CW-1:0] pw,
    input  logic         final_point,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [CW-1:0] bx,
    output logic [CW-1:0] by,
    output logic [CW-1:0] bz,
    output logic [CW-1:0] bw,
    output logic         run_end,
    output logic         curve_end
);

    logic     joint_mode_reg;
    logic [1:0] seen_reg;
    logic [1:0] seen_next;
    coord_t   win_reg [3][LANES];
    coord_t   seg_reg [4][LANES];
    logic     seg_busy_reg;
    bez_sel_t seg_k_reg;
    bez_sel_t seg_last_k_reg;
    logic     seg_fin_reg;

    logic signed [SUM_W-1:0]  s1_sum_reg  [LANES];
    logic signed [SUM_W-1:0]  s1_sum_next [LANES];
    logic                     s1_valid_reg;
    tag_t                     s1_tag_reg;
    tag_t                     s1_tag_next;

    logic [U_W-1:0]           s2_u_reg    [LANES];
    logic [U_W-1:0]           s2_u_next   [LANES];
    logic                     s2_neg_reg  [LANES];
    logic                     s2_valid_reg;
    tag_t                     s2_tag_reg;

    logic [U_W+M_LO_W-1:0]    s3_plo_reg  [LANES];
    logic [U_W+M_LO_W-1:0]    s3_plo_next [LANES];
    logic [U_W+M_HI_W-1:0]    s3_phi_reg  [LANES];
    logic [U_W+M_HI_W-1:0]    s3_phi_next [LANES];
    logic                     s3_neg_reg  [LANES];
    logic                     s3_valid_reg;
    tag_t                     s3_tag_reg;

    logic [Q_W-1:0]           s4_q_reg    [LANES];
    logic [Q_W-1:0]           s4_q_next   [LANES];
    logic                     s4_neg_reg  [LANES];
    logic                     s4_valid_reg;
    tag_t                     s4_tag_reg;

    coord_t                   out_b_reg   [LANES];
    coord_t                   out_b_next  [LANES];
    logic                     out_valid_reg;
    tag_t                     out_tag_reg;

    coord_t   in_raw [LANES];
    coord_t   cur    [LANES];
    logic     adv;
    logic     seg_at_last;
    logic     seg_issue;
    logic     in_acc;
    logic     seg_load;

    assign in_raw[0] = px;
    assign in_raw[1] = py;
    assign in_raw[2] = pz;
    assign in_raw[3] = pw;

    always_comb
    begin
        for (int c = 0; c < LANES; c++)
        begin
            cur[c] = (c < COMPONENTS) ? in_raw[c] : '0;
        end
    end

    assign adv         = !out_valid_reg || out_ready;
    assign seg_at_last = (seg_k_reg == seg_last_k_reg);
    assign seg_issue   = seg_busy_reg && adv;
    assign in_ready    = !seg_busy_reg || (seg_at_last && adv);
    assign in_acc      = in_valid && in_ready;
    assign seg_load    = in_acc && (seen_reg == 2'd3);

    always_comb
    begin
        seen_next = seen_reg;
        if (in_acc)
        begin
            if (final_point)
            begin
                seen_next = 2'd0;
            end
            else if (seen_reg != 2'd3)
            begin
                seen_next = seen_reg + 2'd1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_mode_reg <= 1'b0;
            seen_reg       <= 2'd0;
            seg_busy_reg   <= 1'b0;
            seg_k_reg      <= BEZ_B0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (joint_mode_wr_en)
            begin
                joint_mode_reg <= joint_mode_wr_data;
            end
            seen_reg <= seen_next;
            if (seg_load)
            begin
                seg_busy_reg <= 1'b1;
                seg_k_reg    <= BEZ_B0;
            end
            else if (seg_issue)
            begin
                if (seg_at_last)
                begin
                    seg_busy_reg <= 1'b0;
                end
                else
                begin
                    seg_k_reg <= bez_sel_t'(seg_k_reg + 2'd1);
                end
            end
            if (adv)
            begin
                s1_valid_reg  <= seg_busy_reg;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // window and segment hold
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                win_reg[0][c] <= win_reg[1][c];
                win_reg[1][c] <= win_reg[2][c];
                win_reg[2][c] <= cur[c];
            end
        end
        if (seg_load)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                seg_reg[0][c] <= win_reg[0][c];
                seg_reg[1][c] <= win_reg[1][c];
                seg_reg[2][c] <= win_reg[2][c];
                seg_reg[3][c] <= cur[c];
            end
            seg_last_k_reg <= (joint_mode_reg && !final_point) ? BEZ_B2 : BEZ_B3;
            seg_fin_reg    <= final_point;
        end
    end

    // weighted sum of the selected Bezier point
    always_comb
    begin
        logic signed [SUM_W-1:0] e0;
        logic signed [SUM_W-1:0] e1;
        logic signed [SUM_W-1:0] e2;
        logic signed [SUM_W-1:0] e3;
        logic signed [SUM_W-1:0] op_a;
        logic signed [SUM_W-1:0] op_b;
        logic signed [SUM_W-1:0] op_d;
        for (int c = 0; c < LANES; c++)
        begin
            e0 = SUM_W'(seg_reg[0][c]);
            e1 = SUM_W'(seg_reg[1][c]);
            e2 = SUM_W'(seg_reg[2][c]);
            e3 = SUM_W'(seg_reg[3][c]);
            unique case (seg_k_reg)
                BEZ_B0:
                begin
                    op_a = e0;
                    op_b = e1 <<< 2;
                    op_d = e2;
                end
                BEZ_B1:
                begin
                    op_a = '0;
                    op_b = e1 <<< 2;
                    op_d = e2 <<< 1;
                end
                BEZ_B2:
                begin
                    op_a = '0;
                    op_b = e1 <<< 1;
                    op_d = e2 <<< 2;
                end
                BEZ_B3:
                begin
                    op_a = e1;
                    op_b = e2 <<< 2;
                    op_d = e3;
                end
                default:
                begin
                    op_a = '0;
                    op_b = '0;
                    op_d = '0;
                end
            endcase
            s1_sum_next[c] = op_a + op_b + op_d;
        end
        s1_tag_next.run_end   = seg_at_last;
        s1_tag_next.curve_end = seg_at_last && seg_fin_reg;
    end

    // rounded magnitude, halved; multiply by reciprocal of three in two parts
    always_comb
    begin
        logic [SUM_W-1:0] t;
        for (int c = 0; c < LANES; c++)
        begin
            t = s1_sum_reg[c][SUM_W-1] ? (~s1_sum_reg[c] + SUM_W'(4))
                                       : (s1_sum_reg[c] + SUM_W'(3));
            s2_u_next[c]   = t[U_W:1];
            s3_plo_next[c] = (U_W+M_LO_W)'(s2_u_reg[c]) * (U_W+M_LO_W)'(RECIP_LO);
            s3_phi_next[c] = (U_W+M_HI_W)'(s2_u_reg[c]) * (U_W+M_HI_W)'(RECIP_HI);
        end
    end

    // combine partial products, restore sign
    always_comb
    begin
        logic [P_W-1:0] full;
        logic [Q_W-1:0] sq;
        for (int c = 0; c < LANES; c++)
        begin
            full = {s3_phi_reg[c], {M_LO_W{1'b0}}} + P_W'(s3_plo_reg[c]);
            s4_q_next[c] = full[P_W-1:RECIP_SHIFT];
            sq = s4_neg_reg[c] ? (~s4_q_reg[c] + Q_W'(1)) : s4_q_reg[c];
            out_b_next[c] = sq[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                s1_sum_reg[c] <= s1_sum_next[c];
                s2_u_reg[c]   <= s2_u_next[c];
                s2_neg_reg[c] <= s1_sum_reg[c][SUM_W-1];
                s3_plo_reg[c] <= s3_plo_next[c];
                s3_phi_reg[c] <= s3_phi_next[c];
                s3_neg_reg[c] <= s2_neg_reg[c];
                s4_q_reg[c]   <= s4_q_next[c];
                s4_neg_reg[c] <= s3_neg_reg[c];
                out_b_reg[c]  <= out_b_next[c];
            end
            s1_tag_reg  <= s1_tag_next;
            s2_tag_reg  <= s1_tag_reg;
            s3_tag_reg  <= s2_tag_reg;
            s4_tag_reg  <= s3_tag_reg;
            out_tag_reg <= s4_tag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign bx        = out_b_reg[0];
    assign by        = out_b_reg[1];
    assign bz        = out_b_reg[2];
    assign bw        = out_b_reg[3];
    assign run_end   = out_tag_reg.run_end;
    assign curve_end = out_tag_reg.curve_end;

    a_hold_mid_segment: assert property (@(posedge clk) disable iff (!rst_n)
        seg_busy_reg && !seg_at_last |-> !in_ready)
        else $error("input taken while segment still issuing");

    a_final_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && final_point |=> seen_reg == 2'd0)
        else $error("point count not cleared after final point");

    a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        seg_busy_reg |-> seg_k_reg <= seg_last_k_reg)
        else $error("segment select past last point");

    a_curve_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_tag_reg.curve_end |-> out_tag_reg.run_end)
        else $error("curve end without run end");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg)
        else $error("pipeline word dropped during stall");

endmodule

// ----- tb/tb_bspline_to_bezier_converter.sv -----
`timescale 1ns / 1ps
// Testbench for bspline_to_bezier_converter: directed curves and random curve streams
// with idling and a long output stall, checked against an in-bench segment predictor.
// Depends on bsbz_pkg and the converter RTL.
module tb_bspline_to_bezier_converter
    import bsbz_pkg::*;
();

    typedef struct {
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
        logic [CW-1:0] bz;
        logic [CW-1:0] bw;
        logic          run_end;
        logic          curve_end;
    } bez_word_t;

    logic          clk;
    logic          rst_n;
    logic          joint_mode_wr_en;
    logic          joint_mode_wr_data;
    logic          in_valid;
    logic          in_ready;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic [CW-1:0] pw;
    logic          final_point;
    logic          out_valid;
    logic          out_ready;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    logic [CW-1:0] bz;
    logic [CW-1:0] bw;
    logic          run_end;
    logic          curve_end;

    bez_word_t bez_expected[$];
    longint    ctrl_pts[0:2][0:3];
    int        pts_held = 0;
    logic      shadow_mode = 1'b0;
    int        error_count = 0;
    int        tx_idle_pct;
    int        rx_idle_pct;
    logic      stall_request;
    logic      stall_taken;
    int        hold_left;

    bspline_to_bezier_converter DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .joint_mode_wr_en   (joint_mode_wr_en),
        .joint_mode_wr_data (joint_mode_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .px                 (px),
        .py                 (py),
        .pz                 (pz),
        .pw                 (pw),
        .final_point        (final_point),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .bx                 (bx),
        .by                 (by),
        .bz                 (bz),
        .bw                 (bw),
        .run_end            (run_end),
        .curve_end          (curve_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint round_div6(input longint s);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q = (mag + 3) / 6;
        return (s < 0) ? -q : q;
    endfunction

    task automatic absorb_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                input logic [CW-1:0] z, input logic [CW-1:0] w,
                                input logic fin);
        longint    cur[0:3];
        longint    b[0:3][0:3];
        int        n;
        bez_word_t wd;
        cur[0] = $signed(x);
        cur[1] = $signed(y);
        cur[2] = $signed(z);
        cur[3] = $signed(w);
        if (pts_held >= 3)
        begin
            for (int c = 0; c < 4; c++)
            begin
                b[0][c] = round_div6(ctrl_pts[0][c] + 4 * ctrl_pts[1][c] + ctrl_pts[2][c]);
                b[1][c] = round_div6(4 * ctrl_pts[1][c] + 2 * ctrl_pts[2][c]);
                b[2][c] = round_div6(2 * ctrl_pts[1][c] + 4 * ctrl_pts[2][c]);
                b[3][c] = round_div6(ctrl_pts[1][c] + 4 * ctrl_pts[2][c] + cur[c]);
            end
            n = (shadow_mode && !fin) ? 3 : 4;
            for (int k = 0; k < n; k++)
            begin
                wd.bx        = CW'(b[k][0]);
                wd.by        = CW'(b[k][1]);
                wd.bz        = CW'(b[k][2]);
                wd.bw        = CW'(b[k][3]);
                wd.run_end   = (k == n - 1);
                wd.curve_end = (k == n - 1) && fin;
                bez_expected.insert(bez_expected.size(), wd);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            ctrl_pts[0][c] = ctrl_pts[1][c];
            ctrl_pts[1][c] = ctrl_pts[2][c];
            ctrl_pts[2][c] = cur[c];
        end
        if (fin)
            pts_held = 0;
        else if (pts_held < 3)
            pts_held++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (joint_mode_wr_en)
                shadow_mode = joint_mode_wr_data;
            if (in_valid && in_ready)
                absorb_point(px, py, pz, pw, final_point);
        end
    end

    task automatic report_field(input string name, input logic [CW-1:0] want,
                                input logic [CW-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        bez_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (bez_expected.size() == 0)
            begin
                $error("unexpected result word: bx %h by %h bz %h bw %h", bx, by, bz, bw);
                error_count++;
            end
            else
            begin
                want = bez_expected.pop_front();
                report_field("bx", want.bx, bx);
                report_field("by", want.by, by);
                report_field("bz", want.bz, bz);
                report_field("bw", want.bw, bw);
                report_field("run_end", CW'(want.run_end), CW'(run_end));
                report_field("curve_end", CW'(want.curve_end), CW'(curve_end));
            end
        end
    end

    initial
    begin
        out_ready   = 1'b0;
        hold_left   = 0;
        stall_taken = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stall_request && !stall_taken)
            begin
                stall_taken = 1'b1;
                hold_left   = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
            @(posedge clk);
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        int s;
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4:
            begin
                s = $urandom_range(2000);
                return CW'(s - 1000);
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [CW-1:0] z, input logic [CW-1:0] w,
                             input logic fin);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        px          <= x;
        py          <= y;
        pz          <= z;
        pw          <= w;
        final_point <= fin;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic stop_words();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        stop_words();
        while (bez_expected.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_joint_mode(input logic m);
        joint_mode_wr_data <= m;
        joint_mode_wr_en   <= 1'b1;
        @(posedge clk);
        joint_mode_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_short_curves();
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b1);
        send_word(32'h1, 32'h2, 32'h3, 32'h4, 1'b0);
        send_word(32'h5, 32'h6, 32'h7, 32'h8, 1'b1);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_word(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_extremes();
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_word(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_rounding_ties();
        send_word(32'd3, -32'sd3, 32'd9, -32'sd9, 1'b0);
        send_word(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_word(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_word(32'd3, -32'sd3, 32'd15, -32'sd15, 1'b0);
        send_word(32'd1, -32'sd1, 32'd2, -32'sd2, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_shared_joints();
        set_joint_mode(1'b1);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_word(32'h0002_8000, 32'hFFFD_8000, 32'h1234_5678, 32'hEDCB_A988, 1'b0);
        send_word(32'h0, 32'h1, 32'h2, 32'h3, 1'b0);
        send_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
        send_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 1'b0);
        send_word(32'h1, 32'h0, 32'hFFFF_FFFF, 32'h8000_0001, 1'b1);
        wait_for_drain();
    endtask

    task automatic run_random_curves(input int items, input int tx_pct, input int rx_pct);
        int   sent;
        int   len;
        logic fin;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : $urandom_range(4, 10);
            for (int i = 0; i < len; i++)
            begin
                fin = (i == len - 1) || ($urandom_range(99) < 2);
                send_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(), fin);
                sent++;
                if (fin)
                    break;
            end
        end
        wait_for_drain();
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_request <= 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i == 29);
        wait_for_drain();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        joint_mode_wr_en   = 1'b0;
        joint_mode_wr_data = 1'b0;
        in_valid           = 1'b0;
        px                 = '0;
        py                 = '0;
        pz                 = '0;
        pw                 = '0;
        final_point        = 1'b0;
        stall_request      = 1'b0;
        tx_idle_pct        = 0;
        rx_idle_pct        = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_joint_mode(1'b0);
        tx_idle_pct = 19;
        rx_idle_pct = 62;
        test_short_curves();
        test_extremes();
        test_rounding_ties();
        test_shared_joints();

        set_joint_mode(1'b0);
        run_random_curves(140, 19, 62);
        set_joint_mode(1'b1);
        run_random_curves(140, 62, 19);
        set_joint_mode(1'b0);
        run_random_curves(70, 0, 0);
        set_joint_mode(1'b1);
        run_random_curves(70, 0, 0);

        set_joint_mode(1'b0);
        test_output_stall();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bsbz_pkg.sv
hdl/bspline_to_bezier_converter.sv
tb/tb_bspline_to_bezier_converter.sv
